// ===== rtl/core/pwag_pkg.sv =====
// Package for the perspective warp address generator.
// Holds the request and result payload types, the coefficient set and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pwag_pkg;

  localparam int COEF_W = 48;
  localparam int SUM_W  = 64;
  localparam int COORD_W = 12;
  localparam int SRC_W   = 10;

  localparam logic signed [SUM_W-1:0] ONE_Q32 = 64'sd4294967296;

  typedef enum logic [3:0] {
    REG_COEF_XX = 4'd0,
    REG_COEF_XY = 4'd1,
    REG_COEF_XO = 4'd2,
    REG_COEF_YX = 4'd3,
    REG_COEF_YY = 4'd4,
    REG_COEF_YO = 4'd5,
    REG_COEF_WX = 4'd6,
    REG_COEF_WY = 4'd7
  } reg_idx_e;

  typedef struct packed {
    logic [COORD_W-1:0] dst_x;
    logic [COORD_W-1:0] dst_y;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [SRC_W-1:0]   src_x;
    logic [SRC_W-1:0]   src_y;
    logic               in_bounds;
  } out_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] xx;
    logic signed [COEF_W-1:0] xy;
    logic signed [COEF_W-1:0] xo;
    logic signed [COEF_W-1:0] yx;
    logic signed [COEF_W-1:0] yy;
    logic signed [COEF_W-1:0] yo;
    logic signed [COEF_W-1:0] wx;
    logic signed [COEF_W-1:0] wy;
  } coef_set_t;

  // Classified request handed from the front end to the divider.
  typedef struct packed {
    logic               valid;
    logic               dead;
    logic [COORD_W-1:0] dst_x;
    logic [COORD_W-1:0] dst_y;
    logic [SUM_W-1:0]   nx;
    logic [SUM_W-1:0]   ny;
    logic [SUM_W-1:0]   den;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/core/pwag_front.sv =====
// Front end: projective multiply, sums, sign normalisation and request classification.
// Three register stages. Depends on pwag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwag_front #(
  parameter int DST_SIZE = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  pwag_pkg::in_item_t  in_item_i,
  input  pwag_pkg::coef_set_t coef_i,
  output pwag_pkg::job_t      job_o
);
  import pwag_pkg::*;

  localparam logic [16:0] DST_LIM = 17'(DST_SIZE);
  localparam int PW = COEF_W + COORD_W + 1;

  logic signed [COORD_W:0] xs, ys;
  logic signed [PW-1:0] p_xx_d, p_xy_d, p_yx_d, p_yy_d, p_wx_d, p_wy_d;

  logic                 v1_q;
  logic [COORD_W-1:0]   x1_q, y1_q;
  logic signed [PW-1:0] p_xx_q, p_xy_q, p_yx_q, p_yy_q, p_wx_q, p_wy_q;
  logic signed [COEF_W-1:0] c_xo_q, c_yo_q;

  logic                  v2_q, raster_ok2_q;
  logic [COORD_W-1:0]    x2_q, y2_q;
  logic signed [SUM_W-1:0] nx2_q, ny2_q, w2_q;
  logic signed [SUM_W-1:0] nx_d, ny_d, w_d;

  logic [SUM_W-1:0] nxa, nya, den;
  logic             neg_w;
  job_t             job_d, job_q;

  assign xs = $signed({1'b0, in_item_i.dst_x});
  assign ys = $signed({1'b0, in_item_i.dst_y});

  assign p_xx_d = PW'(coef_i.xx) * PW'(xs);
  assign p_xy_d = PW'(coef_i.xy) * PW'(ys);
  assign p_yx_d = PW'(coef_i.yx) * PW'(xs);
  assign p_yy_d = PW'(coef_i.yy) * PW'(ys);
  assign p_wx_d = PW'(coef_i.wx) * PW'(xs);
  assign p_wy_d = PW'(coef_i.wy) * PW'(ys);

  assign nx_d = SUM_W'(p_xx_q) + SUM_W'(p_xy_q) + SUM_W'(c_xo_q);
  assign ny_d = SUM_W'(p_yx_q) + SUM_W'(p_yy_q) + SUM_W'(c_yo_q);
  assign w_d  = SUM_W'(p_wx_q) + SUM_W'(p_wy_q) + ONE_Q32;

  // negative denominator: flip all three, quotient unchanged
  always_comb begin
    neg_w = w2_q[SUM_W-1];
    den   = neg_w ? 64'(-w2_q)  : 64'(w2_q);
    nxa   = neg_w ? 64'(-nx2_q) : 64'(nx2_q);
    nya   = neg_w ? 64'(-ny2_q) : 64'(ny2_q);
    job_d.valid = v2_q;
    job_d.dead  = !raster_ok2_q || (w2_q == '0) || nxa[SUM_W-1] || nya[SUM_W-1];
    job_d.dst_x = x2_q;
    job_d.dst_y = y2_q;
    job_d.nx    = nxa;
    job_d.ny    = nya;
    job_d.den   = den;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      job_q <= '0;
    end else begin
      v1_q  <= in_valid_i;
      v2_q  <= v1_q;
      job_q <= job_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q   <= in_item_i.dst_x;
    y1_q   <= in_item_i.dst_y;
    p_xx_q <= p_xx_d;
    p_xy_q <= p_xy_d;
    p_yx_q <= p_yx_d;
    p_yy_q <= p_yy_d;
    p_wx_q <= p_wx_d;
    p_wy_q <= p_wy_d;
    c_xo_q <= coef_i.xo;
    c_yo_q <= coef_i.yo;

    x2_q         <= x1_q;
    y2_q         <= y1_q;
    raster_ok2_q <= ({5'd0, x1_q} < DST_LIM) && ({5'd0, y1_q} < DST_LIM);
    nx2_q        <= nx_d;
    ny2_q        <= ny_d;
    w2_q         <= w_d;
  end

  assign job_o = job_q;

endmodule

`default_nettype wire

// ===== rtl/core/pwag_div.sv =====
// Back end: pipelined restoring divider for both axes, one quotient bit per stage,
// then bounds test, round half up and clamp. Depends on pwag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwag_div #(
  parameter int SRC_WIDTH  = 1024,
  parameter int SRC_HEIGHT = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pwag_pkg::job_t      job_i,
  output logic                res_valid_o,
  output pwag_pkg::out_item_t res_o
);
  import pwag_pkg::*;

  localparam int SMAX = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
  // quotient of 2n/d, bounded below 2*size
  localparam int QB = $clog2(SMAX) + 1;
  localparam int RW = SUM_W + 1 + QB;
  localparam logic [17:0] LIM_X = 18'(2 * SRC_WIDTH);
  localparam logic [17:0] LIM_Y = 18'(2 * SRC_HEIGHT);
  localparam logic [17:0] MAX_X = 18'(SRC_WIDTH - 1);
  localparam logic [17:0] MAX_Y = 18'(SRC_HEIGHT - 1);

  logic               vld_q  [QB+1];
  logic               dead_q [QB+1];
  logic [COORD_W-1:0] x_q    [QB+1];
  logic [COORD_W-1:0] y_q    [QB+1];
  logic [QB-1:0]      qx_q   [QB+1];
  logic [QB-1:0]      qy_q   [QB+1];
  logic [RW-1:0]      rx_q   [QB];
  logic [RW-1:0]      ry_q   [QB];
  logic [RW-1:0]      dv_q   [QB];

  logic [RW-1:0] twon_x, twon_y, dtop, dv0;
  logic          ovf;

  assign twon_x = RW'({job_i.nx, 1'b0});
  assign twon_y = RW'({job_i.ny, 1'b0});
  assign dv0    = RW'(job_i.den);
  assign dtop   = dv0 << QB;
  // quotient too wide for the stages: certainly off the source
  assign ovf    = (twon_x >= dtop) || (twon_y >= dtop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= job_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    dead_q[0] <= job_i.dead || ovf;
    x_q[0]    <= job_i.dst_x;
    y_q[0]    <= job_i.dst_y;
    qx_q[0]   <= '0;
    qy_q[0]   <= '0;
    rx_q[0]   <= twon_x;
    ry_q[0]   <= twon_y;
    dv_q[0]   <= dv0;
  end

  for (genvar g = 0; g < QB; g++) begin : g_stage
    localparam int K = QB - 1 - g;
    logic [RW-1:0] dsh;
    logic          bx, by;
    logic [QB:0]   qx_n, qy_n;

    assign dsh  = dv_q[g] << K;
    assign bx   = rx_q[g] >= dsh;
    assign by   = ry_q[g] >= dsh;
    assign qx_n = {qx_q[g], bx};
    assign qy_n = {qy_q[g], by};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      dead_q[g+1] <= dead_q[g];
      x_q[g+1]    <= x_q[g];
      y_q[g+1]    <= y_q[g];
      qx_q[g+1]   <= qx_n[QB-1:0];
      qy_q[g+1]   <= qy_n[QB-1:0];
    end

    if (g < QB - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rx_q[g+1] <= bx ? (rx_q[g] - dsh) : rx_q[g];
        ry_q[g+1] <= by ? (ry_q[g] - dsh) : ry_q[g];
        dv_q[g+1] <= dv_q[g];
      end
    end
  end

  logic [17:0] q2x, q2y, rndx, rndy, clx, cly;
  logic        inb;
  out_item_t   res_d, res_q;
  logic        res_vld_q;

  // round(q) = floor((floor(2q) + 1) / 2)
  always_comb begin
    q2x  = 18'(qx_q[QB]);
    q2y  = 18'(qy_q[QB]);
    rndx = (q2x + 18'd1) >> 1;
    rndy = (q2y + 18'd1) >> 1;
    clx  = (rndx > MAX_X) ? MAX_X : rndx;
    cly  = (rndy > MAX_Y) ? MAX_Y : rndy;
    inb  = !dead_q[QB] && (q2x < LIM_X) && (q2y < LIM_Y);
    res_d.out_x     = x_q[QB];
    res_d.out_y     = y_q[QB];
    res_d.src_x     = inb ? clx[SRC_W-1:0] : '0;
    res_d.src_y     = inb ? cly[SRC_W-1:0] : '0;
    res_d.in_bounds = inb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= vld_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/pwag_fifo.sv =====
// Result queue between the divider and the output port.
// Register array with wrap-bit pointers. Depends on pwag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwag_fifo #(
  parameter int DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  pwag_pkg::out_item_t data_i,
  input  logic                rd_i,
  output pwag_pkg::out_item_t data_o,
  output logic                empty_o
);
  import pwag_pkg::*;

  localparam int AW = $clog2(DEPTH);

  out_item_t     mem_q [DEPTH];
  logic [AW:0]   wp_q, rp_q;

  assign empty_o = (wp_q == rp_q);
  assign data_o  = mem_q[rp_q[AW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 1'b1;
      if (rd_i && !empty_o) rp_q <= rp_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q[AW-1:0]] <= data_i;
  end

endmodule

`default_nettype wire

// ===== rtl/core/perspective_warp_address_gen.sv =====
// Inverse perspective warp address generator, nearest neighbour.
// Requests pass through the front end, the one-bit-per-stage divider pipeline and the result queue.
// Throughput: one request per cycle while results are popped; full rises when the
//   result queue plus requests in flight reach its depth.
// Reset: asynchronous, active low; coefficients return to identity, queue empties.
`timescale 1ns / 1ps
`default_nettype none

module perspective_warp_address_gen #(
  parameter int SRC_WIDTH  = 1024,
  parameter int SRC_HEIGHT = 1024,
  parameter int DST_SIZE   = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  pwag_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output pwag_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_idx_i,
  input  logic [47:0]         cfg_wdata_i
);
  import pwag_pkg::*;

  localparam int SMAX  = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
  localparam int LAT   = $clog2(SMAX) + 6;
  localparam int DEPTH = 2 ** $clog2(LAT + 1);
  localparam int OW    = $clog2(DEPTH + 1);

  coef_set_t coef_q;
  logic [OW-1:0] occ_q;
  logic          acc_in, acc_out;
  job_t          job;
  logic          res_valid;
  out_item_t     res;

  assign acc_in  = push && !full;
  assign acc_out = pop && !empty;
  assign full    = (occ_q == OW'(DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.xx <= 48'sd4294967296;
      coef_q.xy <= '0;
      coef_q.xo <= '0;
      coef_q.yx <= '0;
      coef_q.yy <= 48'sd4294967296;
      coef_q.yo <= '0;
      coef_q.wx <= '0;
      coef_q.wy <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COEF_XX: coef_q.xx <= cfg_wdata_i;
        REG_COEF_XY: coef_q.xy <= cfg_wdata_i;
        REG_COEF_XO: coef_q.xo <= cfg_wdata_i;
        REG_COEF_YX: coef_q.yx <= cfg_wdata_i;
        REG_COEF_YY: coef_q.yy <= cfg_wdata_i;
        REG_COEF_YO: coef_q.yo <= cfg_wdata_i;
        REG_COEF_WX: coef_q.wx <= cfg_wdata_i;
        REG_COEF_WY: coef_q.wy <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // credit count: requests in flight plus results queued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (acc_in && !acc_out) begin
      occ_q <= occ_q + 1'b1;
    end else if (!acc_in && acc_out) begin
      occ_q <= occ_q - 1'b1;
    end
  end

  pwag_front #(.DST_SIZE(DST_SIZE)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(acc_in),
    .in_item_i (in_item_i),
    .coef_i    (coef_q),
    .job_o     (job)
  );

  pwag_div #(.SRC_WIDTH(SRC_WIDTH), .SRC_HEIGHT(SRC_HEIGHT)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (job),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  pwag_fifo #(.DEPTH(DEPTH)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (res_valid),
    .data_i (res),
    .rd_i   (pop),
    .data_o (out_item_o),
    .empty_o(empty)
  );

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(DEPTH)) else $error("credit count above queue depth");

  a_occ_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in && !acc_out) |=> occ_q == $past(occ_q) + 1'b1)
    else $error("credit count missed a request");

  a_res_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> occ_q != '0) else $error("result without credit");

  a_queue_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> occ_q != '0) else $error("queued result without credit");

endmodule

`default_nettype wire
